### hw/rtl/bmdf_pkg.sv
package bmdf_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned NUM_LANES = 4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] class_id;
    logic signed [FIELD_W-1:0] x_pos;
    logic signed [FIELD_W-1:0] y_pos;
    logic signed [FIELD_W-1:0] box_height;
    logic signed [FIELD_W-1:0] box_width;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] last_class_id;
    logic signed [FIELD_W-1:0] median_x;
    logic signed [FIELD_W-1:0] median_y;
    logic signed [FIELD_W-1:0] median_height;
    logic signed [FIELD_W-1:0] median_width;
  } out_t;

  // One stored record: lane 3 x, lane 2 y, lane 1 height, lane 0 width.
  typedef logic [NUM_LANES-1:0][FIELD_W-1:0] rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic last_j;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/bmdf_ctrl.sv
module bmdf_ctrl
  import bmdf_pkg::*;
#(
  parameter int unsigned RECORDS = 3,
  parameter int unsigned AW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_addr_a,
  output logic [AW-1:0] rd_addr_b
);

  localparam logic [AW-1:0] LAST = AW'(RECORDS - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr = 1'b1;
          if (cnt_r == LAST) begin
            cnt_nxt   = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_SCAN;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // compare record i against every record j to find its rank
        cmd.rd     = 1'b1;
        cmd.last_j = (j_r == LAST);
        if (j_r == LAST) begin
          j_nxt = '0;
          if (i_r == LAST) begin
            i_nxt     = '0;
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign wr_addr   = cnt_r;
  assign rd_addr_a = i_r;
  assign rd_addr_b = j_r;

endmodule

### hw/rtl/bmdf_datapath.sv
module bmdf_datapath
  import bmdf_pkg::*;
#(
  parameter int unsigned RECORDS = 3,
  parameter int unsigned AW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  in_t           in_data,
  input  cmd_t          cmd,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output sts_t          sts,
  output logic          out_valid,
  input  logic          out_ready,
  output out_t          out_data
);

  localparam bit            EVEN    = (RECORDS % 2) == 0;
  localparam logic [AW-1:0] LO_RANK = AW'((RECORDS - 1) / 2);
  localparam logic [AW-1:0] HI_RANK = AW'(RECORDS / 2);

  rec_t mem_r [RECORDS];
  rec_t rd_a_r, rd_b_r;
  logic rd_vld_r, last_r, ji_lt_r;

  logic [FIELD_W-1:0] last_id_r;

  logic [NUM_LANES-1:0][AW-1:0]      rank_r, rank_nxt;
  logic [NUM_LANES-1:0][FIELD_W-1:0] lo_r, lo_nxt;
  logic [NUM_LANES-1:0][FIELD_W-1:0] hi_r, hi_nxt;
  logic [NUM_LANES-1:0][FIELD_W-1:0] med;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[wr_addr] <= {in_data.x_pos, in_data.y_pos,
                         in_data.box_height, in_data.box_width};
      last_id_r      <= in_data.class_id;
    end
    if (cmd.rd) begin
      rd_a_r  <= mem_r[rd_addr_a];
      rd_b_r  <= mem_r[rd_addr_b];
      last_r  <= cmd.last_j;
      ji_lt_r <= rd_addr_b < rd_addr_a;
    end
  end

  // Stable rank: record j counts below record i if smaller, or equal and earlier.
  always_comb begin
    logic signed [FIELD_W-1:0] a, b;
    logic                      less;
    logic [AW-1:0]             sum;
    rank_nxt = rank_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    for (int f = 0; f < NUM_LANES; f++) begin
      a    = $signed(rd_a_r[f]);
      b    = $signed(rd_b_r[f]);
      less = (b < a) || ((b == a) && ji_lt_r);
      sum  = rank_r[f] + AW'(less);
      if (rd_vld_r) begin
        if (last_r) begin
          rank_nxt[f] = '0;
          if (sum == LO_RANK) lo_nxt[f] = rd_a_r[f];
          if (sum == HI_RANK) hi_nxt[f] = rd_a_r[f];
        end else begin
          rank_nxt[f] = sum;
        end
      end
    end
  end

  // Mean of the two middle values, truncated toward zero; for odd RECORDS, the middle value.
  always_comb begin
    logic signed [FIELD_W:0] pair, adj;
    for (int f = 0; f < NUM_LANES; f++) begin
      pair = {lo_r[f][FIELD_W-1], lo_r[f]} + {hi_r[f][FIELD_W-1], hi_r[f]};
      adj  = pair + {{FIELD_W{1'b0}}, pair[FIELD_W]};
      med[f] = EVEN ? adj[FIELD_W:1] : lo_r[f];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.rd;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.load) begin
      out_data_r.last_class_id <= last_id_r;
      out_data_r.median_x      <= med[3];
      out_data_r.median_y      <= med[2];
      out_data_r.median_height <= med[1];
      out_data_r.median_width  <= med[0];
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending request");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

  a_no_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (!rd_vld_r && !cmd.rd))
    else $error("store written while ranking is in progress");
`endif

endmodule

### hw/rtl/batch_median_detection_filter_unit.sv
// After the record that completes a batch is accepted, the ranks are found
//   (one rank compare per cycle, all lanes), then DRAIN and LOAD follow;
//   LOAD holds while the previous result is not taken.
// Throughput: one record per cycle within a batch; in_ready stays low from
//   the last record of a batch until its result is loaded into the output.
// Reset: synchronous active-low rst_n empties the batch and drops out_valid.
module batch_median_detection_filter_unit
  import bmdf_pkg::*;
#(
  parameter int unsigned RECORDS = 3
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  bmdf_ctrl #(
    .RECORDS (RECORDS),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b)
  );

  bmdf_datapath #(
    .RECORDS (RECORDS),
    .AW      (AW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
